// File: rtl/set_assoc_position_table_core_macros.svh
`ifndef SET_ASSOC_POSITION_TABLE_CORE_MACROS_SVH
`define SET_ASSOC_POSITION_TABLE_CORE_MACROS_SVH

// assertion helpers, expect clk and rst_n in scope
`ifndef NO_ASSERTIONS
`define SAPT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sapt check failed");
`define SAPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sapt check failed");
`else
`define SAPT_ASSERT_IMPL(label, ante, cons)
`define SAPT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/sapt_pkg.sv
`default_nettype none

package sapt_pkg;

    localparam int KEY_W      = 64;
    localparam int DEPTH_W    = 8;
    localparam int SCORE_W    = 16;
    localparam int BOUND_W    = 2;
    localparam int MOVE_IN_W  = 24;
    localparam int HIT_WAY_W  = 2;
    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 56;
    localparam int MOD_DIGIT  = 4;
    localparam int MOD_STEPS  = KEY_W / MOD_DIGIT;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_AGE   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic [KEY_W-1:0]           key;
        logic signed [DEPTH_W-1:0]  depth;
        logic signed [SCORE_W-1:0]  score;
        logic [BOUND_W-1:0]         bound_kind;
        logic [MOVE_IN_W-1:0]       best_move;
    } item_t;

    typedef enum logic [1:0] {
        F_EMPTY,
        F_MOD,
        F_READY
    } fstate_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_LOOK,
        B_CLR,
        B_FIN
    } bstate_t;

    typedef struct packed {
        logic init_busy;
        logic idle;
    } back_status_t;

endpackage

`default_nettype wire

// File: rtl/sapt_ram.sv
`default_nettype none

module sapt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/sapt_front.sv
`default_nettype none

module sapt_front #(
    parameter int NUM_SETS = 1024,
    parameter int IDX_W    = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sapt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [1:0]                        s_tuser,
    input  wire sapt_pkg::back_status_t            status,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output sapt_pkg::item_t                        q_item,
    output logic [IDX_W-1:0]                       q_idx
);

    localparam bit POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(NUM_SETS - 1);
    localparam int R_W = IDX_W + 1;
    localparam logic [sapt_pkg::MOD_CNT_W-1:0] CNT_LAST =
        sapt_pkg::MOD_CNT_W'(sapt_pkg::MOD_STEPS - 1);

    sapt_pkg::fstate_t state_reg, state_next;
    sapt_pkg::item_t   item_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [R_W-1:0]    rem_reg;
    logic [R_W-1:0]    rem_step;
    logic [sapt_pkg::KEY_W-1:0] shift_reg;
    logic [sapt_pkg::MOD_CNT_W-1:0] cnt_reg;
    logic              accept;
    sapt_pkg::item_t   in_item;

    always_comb
    begin
        in_item.op         = sapt_pkg::op_t'(s_tuser);
        in_item.key        = s_tdata[63:0];
        in_item.depth      = s_tdata[71:64];
        in_item.score      = s_tdata[87:72];
        in_item.bound_kind = s_tdata[89:88];
        in_item.best_move  = s_tdata[113:90];
    end

    // four remainder digits per cycle, msb first
    always_comb
    begin
        logic [R_W-1:0] t;
        t = rem_reg;
        for (int i = 0; i < sapt_pkg::MOD_DIGIT; i++)
        begin
            t = {t[R_W-2:0], shift_reg[sapt_pkg::KEY_W-1-i]};
            if (t >= R_W'(NUM_SETS))
            begin
                t = t - R_W'(NUM_SETS);
            end
        end
        rem_step = t;
    end

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sapt_pkg::F_EMPTY:
            begin
                if (accept)
                begin
                    state_next = POW2 ? sapt_pkg::F_READY : sapt_pkg::F_MOD;
                end
            end
            sapt_pkg::F_MOD:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = sapt_pkg::F_READY;
                end
            end
            sapt_pkg::F_READY:
            begin
                if (accept)
                begin
                    state_next = POW2 ? sapt_pkg::F_READY : sapt_pkg::F_MOD;
                end
                else if (!q_full)
                begin
                    state_next = sapt_pkg::F_EMPTY;
                end
            end
            default:
            begin
                state_next = sapt_pkg::F_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        q_push   = (state_reg == sapt_pkg::F_READY) && !q_full;
        s_tready = !status.init_busy &&
                   ((state_reg == sapt_pkg::F_EMPTY) ||
                    ((state_reg == sapt_pkg::F_READY) && !q_full));
        q_item   = item_reg;
        q_idx    = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sapt_pkg::F_EMPTY;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == sapt_pkg::F_MOD)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg  <= in_item;
            idx_reg   <= in_item.key[IDX_W-1:0] & IDX_MASK;
            rem_reg   <= '0;
            shift_reg <= in_item.key;
        end
        else if (state_reg == sapt_pkg::F_MOD)
        begin
            rem_reg   <= rem_step;
            shift_reg <= shift_reg << sapt_pkg::MOD_DIGIT;
            if (cnt_reg == CNT_LAST)
            begin
                idx_reg <= rem_step[IDX_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/sapt_queue.sv
`default_nettype none

module sapt_queue #(
    parameter int IDX_W = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire sapt_pkg::item_t  push_item,
    input  wire logic [IDX_W-1:0] push_idx,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output sapt_pkg::item_t       head_item,
    output logic [IDX_W-1:0]      head_idx
);

    sapt_pkg::item_t  item_reg [2];
    logic [IDX_W-1:0] idx_reg  [2];
    logic             wr_reg;
    logic             rd_reg;
    logic [1:0]       count_reg;

    assign full      = count_reg == 2'd2;
    assign valid     = count_reg != 2'd0;
    assign head_item = item_reg[rd_reg];
    assign head_idx  = idx_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wr_reg] <= push_item;
            idx_reg[wr_reg]  <= push_idx;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sapt_back.sv
`default_nettype none
`include "set_assoc_position_table_core_macros.svh"

module sapt_back #(
    parameter int NUM_SETS  = 1024,
    parameter int WAYS      = 4,
    parameter int MOVE_BITS = 24,
    parameter int AGE_BITS  = 16,
    parameter int IDX_W     = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    input  wire sapt_pkg::item_t                q_item,
    input  wire logic [IDX_W-1:0]               q_idx,
    output logic                                q_pop,
    input  wire logic                           table_enable,
    output sapt_pkg::back_status_t              status,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [sapt_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                          m_tuser
);

    localparam int MW      = MOVE_BITS < sapt_pkg::MOVE_IN_W ? MOVE_BITS : sapt_pkg::MOVE_IN_W;
    localparam int WAY_W   = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int O_MOVE  = sapt_pkg::KEY_W;
    localparam int O_SCORE = O_MOVE + MW;
    localparam int O_DEPTH = O_SCORE + sapt_pkg::SCORE_W;
    localparam int O_BOUND = O_DEPTH + sapt_pkg::DEPTH_W;
    localparam int O_AGE   = O_BOUND + sapt_pkg::BOUND_W;
    localparam int ENTRY_W = O_AGE + AGE_BITS;
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(NUM_SETS - 1);

    sapt_pkg::bstate_t state_reg, state_next;
    sapt_pkg::item_t   cur_item_reg;
    logic [IDX_W-1:0]  cur_idx_reg;
    logic [IDX_W-1:0]  row_reg;
    logic [AGE_BITS-1:0] age_reg;

    logic              out_valid_reg;
    logic              hit_reg;
    logic [sapt_pkg::HIT_WAY_W-1:0] hit_way_reg;
    logic [sapt_pkg::MOVE_IN_W-1:0] move_reg;
    logic [sapt_pkg::SCORE_W-1:0]   score_reg;
    logic [sapt_pkg::DEPTH_W-1:0]   depth_reg;
    logic [sapt_pkg::BOUND_W-1:0]   bound_reg;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ROW_W-1:0]  ram_wdata, ram_rdata, put_row;
    logic              res_load, res_free;
    logic              res_hit;
    logic [WAY_W-1:0]  res_way;
    logic              is_mem_op;

    logic [sapt_pkg::KEY_W-1:0]          w_key   [WAYS];
    logic [MW-1:0]                       w_move  [WAYS];
    logic [sapt_pkg::SCORE_W-1:0]        w_score [WAYS];
    logic signed [sapt_pkg::DEPTH_W-1:0] w_depth [WAYS];
    logic [sapt_pkg::BOUND_W-1:0]        w_bound [WAYS];
    logic [AGE_BITS-1:0]                 w_age   [WAYS];

    sapt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            w_key[w]   = ram_rdata[w*ENTRY_W +: sapt_pkg::KEY_W];
            w_move[w]  = ram_rdata[w*ENTRY_W+O_MOVE +: MW];
            w_score[w] = ram_rdata[w*ENTRY_W+O_SCORE +: sapt_pkg::SCORE_W];
            w_depth[w] = ram_rdata[w*ENTRY_W+O_DEPTH +: sapt_pkg::DEPTH_W];
            w_bound[w] = ram_rdata[w*ENTRY_W+O_BOUND +: sapt_pkg::BOUND_W];
            w_age[w]   = ram_rdata[w*ENTRY_W+O_AGE +: AGE_BITS];
        end
    end

    // first matching way for get
    always_comb
    begin
        res_hit = 1'b0;
        res_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!res_hit && (w_key[w] == cur_item_reg.key))
            begin
                res_hit = 1'b1;
                res_way = WAY_W'(w);
            end
        end
    end

    // put: first empty or matching way, else a victim chosen by age and depth
    always_comb
    begin
        logic             fnd;
        logic [WAY_W-1:0] fw;
        logic [WAY_W-1:0] vic;
        logic [WAY_W-1:0] slot;
        logic signed [7:0] best;
        logic signed [7:0] val;
        logic [MW-1:0]    mv;
        logic [ENTRY_W-1:0] ent;
        fnd  = 1'b0;
        fw   = '0;
        vic  = '0;
        best = -8'sd99;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!fnd && ((w_key[w] == '0) || (w_key[w] == cur_item_reg.key)))
            begin
                fnd = 1'b1;
                fw  = WAY_W'(w);
            end
            val = 8'sd0;
            if (w_age[w] == age_reg)
            begin
                val = val - 8'sd6;
            end
            if (w_depth[w] < w_depth[vic])
            begin
                val = val + 8'sd1;
            end
            if (val > best)
            begin
                best = val;
                vic  = WAY_W'(w);
            end
        end
        slot = fnd ? fw : vic;
        mv   = cur_item_reg.best_move[MW-1:0];
        if (fnd && (mv == '0))
        begin
            mv = w_move[fw];
        end
        ent = {age_reg, cur_item_reg.bound_kind, cur_item_reg.depth,
               cur_item_reg.score, mv, cur_item_reg.key};
        put_row = ram_rdata;
        put_row[slot*ENTRY_W +: ENTRY_W] = ent;
    end

    assign res_free  = !out_valid_reg || m_tready;
    assign is_mem_op = (q_item.op == sapt_pkg::OP_PUT) || (q_item.op == sapt_pkg::OP_GET);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sapt_pkg::B_INIT:
            begin
                if (row_reg == ROW_LAST)
                begin
                    state_next = sapt_pkg::B_IDLE;
                end
            end
            sapt_pkg::B_IDLE:
            begin
                if (q_valid && is_mem_op)
                begin
                    state_next = sapt_pkg::B_LOOK;
                end
                else if (q_valid && (q_item.op == sapt_pkg::OP_CLEAR))
                begin
                    state_next = sapt_pkg::B_CLR;
                end
            end
            sapt_pkg::B_LOOK:
            begin
                if (res_free)
                begin
                    state_next = sapt_pkg::B_IDLE;
                end
            end
            sapt_pkg::B_CLR:
            begin
                if (row_reg == ROW_LAST)
                begin
                    state_next = sapt_pkg::B_FIN;
                end
            end
            sapt_pkg::B_FIN:
            begin
                if (res_free)
                begin
                    state_next = sapt_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = sapt_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = row_reg;
        ram_wdata = '0;
        res_load  = 1'b0;
        case (state_reg)
            sapt_pkg::B_INIT, sapt_pkg::B_CLR:
            begin
                ram_we = 1'b1;
            end
            sapt_pkg::B_IDLE:
            begin
                if (q_valid && is_mem_op)
                begin
                    q_pop  = 1'b1;
                    ram_re = 1'b1;
                end
                else if (q_valid && (q_item.op == sapt_pkg::OP_CLEAR))
                begin
                    q_pop = 1'b1;
                end
                else if (q_valid && res_free)
                begin
                    q_pop    = 1'b1;
                    res_load = 1'b1;
                end
            end
            sapt_pkg::B_LOOK:
            begin
                res_load  = res_free;
                ram_we    = res_free && (cur_item_reg.op == sapt_pkg::OP_PUT);
                ram_waddr = cur_idx_reg;
                ram_wdata = put_row;
            end
            sapt_pkg::B_FIN:
            begin
                res_load = res_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sapt_pkg::B_INIT;
            row_reg       <= '0;
            age_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == sapt_pkg::B_INIT) || (state_reg == sapt_pkg::B_CLR))
            begin
                row_reg <= (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
            end
            if (q_pop && (q_item.op == sapt_pkg::OP_AGE))
            begin
                age_reg <= age_reg + 1'b1;
            end
            else if (q_pop && (q_item.op == sapt_pkg::OP_CLEAR))
            begin
                age_reg <= '0;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_item_reg <= q_item;
            cur_idx_reg  <= q_idx;
        end
        if (res_load)
        begin
            hit_reg     <= 1'b0;
            hit_way_reg <= '0;
            move_reg    <= '0;
            score_reg   <= '0;
            depth_reg   <= '0;
            bound_reg   <= '0;
            if ((state_reg == sapt_pkg::B_LOOK) && (cur_item_reg.op == sapt_pkg::OP_GET)
                && table_enable && res_hit)
            begin
                hit_reg     <= 1'b1;
                hit_way_reg <= sapt_pkg::HIT_WAY_W'(res_way);
                move_reg    <= sapt_pkg::MOVE_IN_W'(w_move[res_way]);
                score_reg   <= w_score[res_way];
                depth_reg   <= w_depth[res_way];
                bound_reg   <= w_bound[res_way];
            end
        end
    end

    assign status.init_busy = state_reg == sapt_pkg::B_INIT;
    assign status.idle      = state_reg == sapt_pkg::B_IDLE;
    assign m_tvalid         = out_valid_reg;
    assign m_tuser          = hit_reg;
    assign m_tdata          = {4'b0, bound_reg, depth_reg, score_reg, move_reg, hit_way_reg};

    `SAPT_ASSERT_IMPL(a_load_free, res_load, !out_valid_reg || m_tready)
    `SAPT_ASSERT_IMPL(a_we_state, ram_we, state_reg == sapt_pkg::B_LOOK || state_reg == sapt_pkg::B_CLR || state_reg == sapt_pkg::B_INIT)
    `SAPT_ASSERT_IMPL(a_clr_age, state_reg == sapt_pkg::B_CLR, age_reg == '0)
    `SAPT_ASSERT_NEXT(a_pop_look, q_pop && is_mem_op && status.idle, state_reg == sapt_pkg::B_LOOK)

endmodule

`default_nettype wire

// File: rtl/set_assoc_position_table_core.sv
// set-associative position table
// input stream s_*: one request per item, s_tuser = op (put, get, age, clear),
// s_tdata = key, depth, score, bound_kind, best_move.
// output stream m_*: one result per request, m_tuser = hit, m_tdata = hit_way,
// found_move, found_score, found_depth, found_bound (zero unless a get hits).
// cfg_*: table_enable, taken every cycle; write it only while the block is idle.
// the front computes the set index (the low key bits for a power-of-two set
// count, a serial remainder for other counts, four key bits per cycle) and
// feeds a two-entry queue; the back reads one set row, then writes it back
// for a put. put and get pass the back's idle and look states, a set memory
// read then, for put, a write; clear sweeps NUM_SETS rows, one a cycle.
// a put or get passes the front item register, the queue, the back look state and the result register.
// after reset the store is swept over all NUM_SETS rows with s_tready low.
// a stalled m_tready holds the result register; the queue then fills and
// s_tready drops.
`default_nettype none

module set_assoc_position_table_core #(
    parameter int NUM_SETS  = 1024,
    parameter int WAYS      = 4,
    parameter int MOVE_BITS = 24,
    parameter int AGE_BITS  = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // key, depth, score, bound_kind, best_move
    input  wire logic [sapt_pkg::S_TDATA_W-1:0] s_tdata,
    // op
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // hit_way, found_move, found_score, found_depth, found_bound
    output logic [sapt_pkg::M_TDATA_W-1:0]      m_tdata,
    // hit
    output logic [0:0]                          m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [0:0]                     cfg_data
);

    localparam int IDX_W = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;

    logic                   table_enable_reg;
    sapt_pkg::back_status_t status;
    logic                   q_push, q_full, q_pop, q_valid;
    sapt_pkg::item_t        push_item, head_item;
    logic [IDX_W-1:0]       push_idx, head_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_enable_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            table_enable_reg <= cfg_data[0];
        end
    end

    sapt_front #(
        .NUM_SETS (NUM_SETS),
        .IDX_W    (IDX_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item),
        .q_idx    (push_idx)
    );

    sapt_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .push_idx  (push_idx),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (head_item),
        .head_idx  (head_idx)
    );

    sapt_back #(
        .NUM_SETS  (NUM_SETS),
        .WAYS      (WAYS),
        .MOVE_BITS (MOVE_BITS),
        .AGE_BITS  (AGE_BITS),
        .IDX_W     (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (head_item),
        .q_idx        (head_idx),
        .q_pop        (q_pop),
        .table_enable (table_enable_reg),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

`default_nettype wire

// File: dv/set_assoc_position_table_core_tb.sv
`timescale 1ns / 100ps

module set_assoc_position_table_core_tb;

    localparam int N_SETS     = 1024;
    localparam int N_WAYS     = 4;
    localparam int N_ENTRIES  = N_SETS * N_WAYS;
    localparam int CYCLE_MAX  = 3000000;
    localparam int RAND_ITEMS = 1800;

    typedef struct {
        logic        hit;
        logic [1:0]  way;
        logic [23:0] move;
        logic [15:0] score;
        logic [7:0]  depth;
        logic [1:0]  bound;
    } lookup_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [sapt_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = 2'd0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [sapt_pkg::M_TDATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [0:0] cfg_data = 1'b0;

    // table mirror
    logic [63:0] tbl_key[N_ENTRIES];
    logic [23:0] tbl_move[N_ENTRIES];
    logic [15:0] tbl_score[N_ENTRIES];
    logic [7:0]  tbl_depth[N_ENTRIES];
    logic [1:0]  tbl_bound[N_ENTRIES];
    logic [15:0] tbl_age[N_ENTRIES];
    logic [15:0] age_now;
    logic        lookup_en;

    sapt_pkg::item_t pending_reqs[$];
    lookup_t lookup_expect[$];
    int      err_count = 0;
    int      accepted = 0;
    int      total_items = 0;
    int      cycles = 0;
    bit      idle_on = 1'b1;
    bit      hold_done = 1'b0;
    int      drv_gap = 0;
    int      mon_gap = 0;
    int      mon_hold = 0;

    set_assoc_position_table_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void wipe_table();
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            tbl_key[i] = '0;
            tbl_move[i] = '0;
            tbl_score[i] = '0;
            tbl_depth[i] = '0;
            tbl_bound[i] = '0;
            tbl_age[i] = '0;
        end
        age_now = '0;
    endfunction

    function automatic void store_entry(int slot, sapt_pkg::item_t it, logic [23:0] mv);
        tbl_key[slot] = it.key;
        tbl_move[slot] = mv;
        tbl_score[slot] = it.score;
        tbl_depth[slot] = it.depth;
        tbl_bound[slot] = it.bound_kind;
        tbl_age[slot] = age_now;
    endfunction

    function automatic void predict_lookup(sapt_pkg::item_t it);
        lookup_t r;
        int base;
        int victim;
        int best;
        int value;
        int slot;
        logic [23:0] mv;
        r = '{1'b0, 2'd0, 24'd0, 16'd0, 8'd0, 2'd0};
        base = int'(it.key % N_SETS) * N_WAYS;
        case (it.op)
            sapt_pkg::OP_PUT:
            begin
                mv = it.best_move;
                victim = base;
                best = -99;
                slot = -1;
                for (int w = 0; w < N_WAYS; w++)
                begin
                    if (slot < 0)
                    begin
                        if (tbl_key[base + w] == '0 || tbl_key[base + w] == it.key)
                        begin
                            slot = base + w;
                        end
                        else
                        begin
                            value = 0;
                            if (tbl_age[base + w] == age_now)
                                value -= 6;
                            if ($signed(tbl_depth[base + w]) < $signed(tbl_depth[victim]))
                                value += 1;
                            if (value > best)
                            begin
                                best = value;
                                victim = base + w;
                            end
                        end
                    end
                end
                if (slot >= 0)
                begin
                    if (mv == '0)
                        mv = tbl_move[slot];
                    store_entry(slot, it, mv);
                end
                else
                begin
                    store_entry(victim, it, mv);
                end
            end
            sapt_pkg::OP_GET:
            begin
                if (lookup_en)
                begin
                    for (int w = N_WAYS - 1; w >= 0; w--)
                    begin
                        if (tbl_key[base + w] == it.key)
                        begin
                            r.hit = 1'b1;
                            r.way = w[1:0];
                            r.move = tbl_move[base + w];
                            r.score = tbl_score[base + w];
                            r.depth = tbl_depth[base + w];
                            r.bound = tbl_bound[base + w];
                        end
                    end
                end
            end
            sapt_pkg::OP_AGE: age_now = age_now + 16'd1;
            default: wipe_table();
        endcase
        lookup_expect.push_back(r);
    endfunction

    function automatic logic [63:0] pick_key();
        logic [9:0] sets[5] = '{10'd0, 10'd1, 10'd1023, 10'd512, 10'd77};
        logic [31:0] highs[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                                  32'h1234_5678, 32'hA5A5_5A5A};
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 64'd0;
        if (r == 1)
            return '1;
        if (r < 4)
            return {$urandom, $urandom};
        return {highs[$urandom_range(0, 5)], 22'($urandom_range(0, 2)),
                sets[$urandom_range(0, 4)]};
    endfunction

    function automatic sapt_pkg::item_t make_item(sapt_pkg::op_t op, logic [63:0] key,
                                                  logic [7:0] dep, logic [15:0] sc,
                                                  logic [1:0] bk, logic [23:0] mv);
        sapt_pkg::item_t it;
        it.op = op;
        it.key = key;
        it.depth = dep;
        it.score = sc;
        it.bound_kind = bk;
        it.best_move = mv;
        return it;
    endfunction

    function automatic sapt_pkg::item_t random_item();
        int r;
        sapt_pkg::op_t op;
        logic [23:0] mv;
        r = $urandom_range(0, 255);
        if (r < 2)
            op = sapt_pkg::OP_CLEAR;
        else if (r < 22)
            op = sapt_pkg::OP_AGE;
        else if (r < 140)
            op = sapt_pkg::OP_PUT;
        else
            op = sapt_pkg::OP_GET;
        mv = ($urandom_range(0, 5) == 0) ? 24'd0 : 24'($urandom);
        return make_item(op, pick_key(), 8'($urandom), 16'($urandom),
                         2'($urandom), mv);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        err_count++;
    endtask

    task automatic send(sapt_pkg::item_t it);
        pending_reqs.push_back(it);
        total_items++;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || lookup_expect.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_enable(logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        lookup_en = v;
        cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(posedge clk)
    begin
        logic nv;
        if (rst_n)
        begin
            nv = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_lookup(pending_reqs.pop_front());
                accepted++;
                nv = 1'b0;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    nv = 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    nv = 1'b1;
                    s_tdata <= {6'd0, pending_reqs[0].best_move, pending_reqs[0].bound_kind,
                                pending_reqs[0].score, pending_reqs[0].depth,
                                pending_reqs[0].key};
                    s_tuser <= pending_reqs[0].op;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        drv_gap = $urandom_range(1, 6);
                end
            end
            s_tvalid <= nv;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (lookup_expect.size() == 0)
                begin
                    report_mismatch("unexpected result", {m_tuser, m_tdata}, 64'd0);
                end
                else
                begin
                    e = lookup_expect.pop_front();
                    if (m_tuser[0] !== e.hit)
                        report_mismatch("hit", m_tuser, e.hit);
                    if (m_tdata[1:0] !== e.way)
                        report_mismatch("hit_way", m_tdata[1:0], e.way);
                    if (m_tdata[25:2] !== e.move)
                        report_mismatch("found_move", m_tdata[25:2], e.move);
                    if (m_tdata[41:26] !== e.score)
                        report_mismatch("found_score", m_tdata[41:26], e.score);
                    if (m_tdata[49:42] !== e.depth)
                        report_mismatch("found_depth", m_tdata[49:42], e.depth);
                    if (m_tdata[51:50] !== e.bound)
                        report_mismatch("found_bound", m_tdata[51:50], e.bound);
                end
            end
            if (!hold_done && accepted >= 400)
            begin
                hold_done = 1'b1;
                mon_hold = 300;
            end
            if (mon_hold > 0)
            begin
                mon_hold--;
                m_tready <= 1'b0;
            end
            else if (mon_gap > 0)
            begin
                mon_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    mon_gap = $urandom_range(1, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        wipe_table();
        lookup_en = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, key zero, move kept on match, replacement
        send(make_item(sapt_pkg::OP_GET, 64'd5, 8'd0, 16'd0, 2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_PUT, 64'd5, 8'h7F, 16'h7FFF, 2'd3, 24'hFFFFFF));
        send(make_item(sapt_pkg::OP_PUT, 64'd5, 8'h80, 16'h8000, 2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_GET, 64'd5, 8'd0, 16'd0, 2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_PUT, 64'd0, 8'd3, 16'd9, 2'd1, 24'd7));
        send(make_item(sapt_pkg::OP_GET, 64'd0, 8'd0, 16'd0, 2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_PUT, '1, 8'h80, 16'hFFFF, 2'd2, 24'h800000));
        send(make_item(sapt_pkg::OP_GET, '1, 8'd0, 16'd0, 2'd0, 24'd0));
        for (int i = 1; i <= 6; i++)
            send(make_item(sapt_pkg::OP_PUT, 64'd5 + (64'(i) << 10), 8'(i * 20 - 60),
                           16'(i), 2'(i), 24'(i)));
        send(make_item(sapt_pkg::OP_AGE, 64'd0, 8'd0, 16'd0, 2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_PUT, 64'd5 + (64'd9 << 10), 8'd1, 16'd1, 2'd1, 24'd1));
        for (int i = 0; i < 4; i++)
            send(make_item(sapt_pkg::OP_GET, 64'd5 + (64'(i + 4) << 10), 8'd0, 16'd0,
                           2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_CLEAR, 64'd0, 8'd0, 16'd0, 2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_GET, 64'd5, 8'd0, 16'd0, 2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_GET, 64'd0, 8'd0, 16'd0, 2'd0, 24'd0));
        wait_drained();

        // disabled lookups, puts still land
        write_enable(1'b0);
        send(make_item(sapt_pkg::OP_PUT, 64'd77, 8'd4, 16'd4, 2'd2, 24'd44));
        send(make_item(sapt_pkg::OP_GET, 64'd77, 8'd0, 16'd0, 2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_GET, 64'd0, 8'd0, 16'd0, 2'd0, 24'd0));
        for (int i = 0; i < 200; i++)
            send(random_item());
        wait_drained();
        write_enable(1'b1);
        send(make_item(sapt_pkg::OP_GET, 64'd77, 8'd0, 16'd0, 2'd0, 24'd0));
        for (int i = 0; i < 900; i++)
            send(random_item());
        wait_drained();

        // replacement once the age has moved past the stored entries
        send(make_item(sapt_pkg::OP_CLEAR, 64'd0, 8'd0, 16'd0, 2'd0, 24'd0));
        for (int i = 0; i < 4; i++)
            send(make_item(sapt_pkg::OP_PUT, 64'd3 + (64'(i + 1) << 10), 8'(i), 16'd0,
                           2'd0, 24'd1));
        idle_on = 1'b0;
        for (int i = 0; i < 3; i++)
            send(make_item(sapt_pkg::OP_AGE, 64'd0, 8'd0, 16'd0, 2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_PUT, 64'd3 + (64'd9 << 10), 8'd0, 16'd0, 2'd0, 24'd2));
        for (int i = 0; i < 5; i++)
            send(make_item(sapt_pkg::OP_GET, 64'd3 + (64'(i + 1) << 10), 8'd0, 16'd0,
                           2'd0, 24'd0));
        send(make_item(sapt_pkg::OP_GET, 64'd3 + (64'd9 << 10), 8'd0, 16'd0, 2'd0, 24'd0));
        wait_drained();
        idle_on = 1'b1;

        write_enable(1'b0);
        for (int i = 0; i < 150; i++)
            send(random_item());
        wait_drained();
        write_enable(1'b1);
        for (int i = 0; i < RAND_ITEMS - 1250; i++)
            send(random_item());
        while (pending_reqs.size() > 200)
            @(posedge clk);
        idle_on = 1'b0;
        wait_drained();
        repeat (50) @(posedge clk);
        if (err_count == 0 && lookup_expect.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
